FILE: sv/psfp_pkg.sv
// Shared types and constants for the particle sensor frame parser.
package psfp_pkg;

   localparam logic [7:0]  START_FIRST  = 8'h42;
   localparam logic [7:0]  START_SECOND = 8'h4D;
   // 0x42 + 0x4D, the sum of the two start bytes
   localparam logic [15:0] SUM_SEED     = 16'h008F;

   localparam int          INDEX_W      = 5;
   localparam logic [4:0]  FIRST_INDEX  = 5'd2;   // first byte after the start pair
   localparam logic [4:0]  SUM_BYTES    = 5'd30;
   localparam logic [4:0]  DATA_FIRST   = 5'd10;
   localparam logic [4:0]  DATA_END     = 5'd28;  // one past the last data byte
   localparam logic [4:0]  LAST_INDEX   = 5'd31;
   localparam int          DATA_COUNT   = 18;
   localparam int          WORD_COUNT   = DATA_COUNT / 2;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_SECOND,
      PH_COLLECT
   } phase_type;

   // one frame byte handed from the framer to the back end
   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [7:0]         data;
   } entry_type;

   typedef struct packed {
      logic [WORD_COUNT-1:0][15:0] words;
      logic                        checksum_ok;
   } result_type;

endpackage

FILE: sv/psfp_front.sv
// Framer: hunts for the start pair and tags each frame byte with its position.
module psfp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [7:0]          req_rx_byte,
   input  logic                accept,
   output logic                push_valid,
   output psfp_pkg::entry_type push_entry
);
   import psfp_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [INDEX_W-1:0] byte_index_ff, byte_index_in;

   // next state
   always_comb begin
      phase_in      = phase_ff;
      byte_index_in = byte_index_ff;
      if (accept) begin
         case (phase_ff)
            PH_SECOND: begin
               if (req_rx_byte == START_SECOND) begin
                  phase_in      = PH_COLLECT;
                  byte_index_in = FIRST_INDEX;
               end else begin
                  phase_in      = PH_HUNT;
                  byte_index_in = '0;
               end
            end
            PH_COLLECT: begin
               if (byte_index_ff == LAST_INDEX) begin
                  phase_in      = PH_HUNT;
                  byte_index_in = '0;
               end else begin
                  byte_index_in = byte_index_ff + 1'b1;
               end
            end
            default: begin
               phase_in      = (req_rx_byte == START_FIRST) ? PH_SECOND : PH_HUNT;
               byte_index_in = '0;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      push_valid       = 1'b0;
      push_entry.index = byte_index_ff;
      push_entry.data  = req_rx_byte;
      case (phase_ff)
         PH_COLLECT: push_valid = req_valid;
         default:    push_valid = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         byte_index_ff <= '0;
      end else begin
         phase_ff      <= phase_in;
         byte_index_ff <= byte_index_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_collect_index: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_COLLECT |-> byte_index_ff >= FIRST_INDEX)
      else $error("collect phase with index below first data position");

   a_hunt_index: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_COLLECT |-> byte_index_ff == '0)
      else $error("index not cleared outside a frame");

   a_start_pair: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_SECOND && req_rx_byte == START_SECOND
      |=> phase_ff == PH_COLLECT && byte_index_ff == FIRST_INDEX)
      else $error("start pair did not open a frame");
`endif

endmodule

FILE: sv/psfp_queue.sv
// Two-entry queue between the framer and the back end.
module psfp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  psfp_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                pop_valid,
   output psfp_pkg::entry_type pop_entry
);
   import psfp_pkg::*;

   entry_type  mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("pop from empty queue");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

FILE: sv/psfp_back.sv
// Back end: checksum accumulation, data byte capture and the result register.
module psfp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  psfp_pkg::entry_type  q_entry,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output psfp_pkg::result_type rsp_result
);
   import psfp_pkg::*;

   logic [15:0]  sum_ff, sum_in;
   logic [7:0]   payload_ff [DATA_COUNT];
   logic [7:0]   check_high_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   result_type   result_ff, result_in;
   logic         is_last;
   logic [4:0]   slot;

   assign is_last = (q_entry.index == LAST_INDEX);
   // a non-final beat never touches the result register, so only the last one waits
   assign q_pop   = q_valid && (!is_last || !rsp_valid_ff || rsp_ready);
   assign slot    = q_entry.index - DATA_FIRST;

   always_comb begin
      sum_in = sum_ff;
      if (q_entry.index == FIRST_INDEX) begin
         sum_in = SUM_SEED + {8'd0, q_entry.data};
      end else if (q_entry.index < SUM_BYTES) begin
         sum_in = sum_ff + {8'd0, q_entry.data};
      end
   end

   always_comb begin
      for (int k = 0; k < WORD_COUNT; k++) begin
         result_in.words[k] = {payload_ff[2*k], payload_ff[2*k+1]};
      end
      result_in.checksum_ok = (sum_ff == {check_high_ff, q_entry.data});
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (q_pop && is_last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         sum_ff <= sum_in;
         if (q_entry.index >= DATA_FIRST && q_entry.index < DATA_END) begin
            payload_ff[slot] <= q_entry.data;
         end
         if (q_entry.index == SUM_BYTES) begin
            check_high_ff <= q_entry.data;
         end
         if (is_last) begin
            result_ff <= result_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

`ifndef NO_ASSERTIONS
   a_seed: assert property (@(posedge clock) disable iff (reset)
      q_pop && q_entry.index == FIRST_INDEX
      |=> sum_ff == SUM_SEED + {8'd0, $past(q_entry.data)})
      else $error("frame sum not seeded with start pair");
`endif

endmodule

FILE: sv/particle_sensor_frame_parser_unit.sv
// Top level of the particle sensor frame parser.
//
// Input channel req_*: one received serial byte per beat (req_rx_byte).
// Output channel rsp_*: one beat per complete 32-byte frame carrying the
// three mass concentrations, six particle counts and checksum_ok. Frames
// with a bad checksum are delivered too, with checksum_ok low.
// A byte is taken every cycle while the two-entry queue between the
// framer and the back end has room. The result of a frame appears at
// rsp_valid after its last byte is accepted, passing through a queue slot
// and then the result register, provided the result register is free.
// Throughput is one byte per cycle while the queue has room.
// If the receiver holds rsp_ready low, the next frame's bytes keep
// flowing until its last byte reaches the back end; that byte waits for
// the result register, the queue fills and req_ready drops.
// Synchronous reset returns the framer to hunting for 0x42, empties the
// queue and drops rsp_valid; no clearing pass is needed.
module particle_sensor_frame_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_pm1_mass,
   output logic [15:0] rsp_pm25_mass,
   output logic [15:0] rsp_pm10_mass,
   output logic [15:0] rsp_count_03,
   output logic [15:0] rsp_count_05,
   output logic [15:0] rsp_count_10,
   output logic [15:0] rsp_count_25,
   output logic [15:0] rsp_count_50,
   output logic [15:0] rsp_count_100,
   output logic        rsp_checksum_ok
);
   import psfp_pkg::*;

   logic       accept;
   logic       push_valid;
   entry_type  push_entry;
   logic       q_full;
   logic       q_valid;
   entry_type  q_entry;
   logic       q_pop;
   result_type result;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   psfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .accept      (accept),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   psfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid && accept),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry)
   );

   psfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (result)
   );

   assign rsp_pm1_mass    = result.words[0];
   assign rsp_pm25_mass   = result.words[1];
   assign rsp_pm10_mass   = result.words[2];
   assign rsp_count_03    = result.words[3];
   assign rsp_count_05    = result.words[4];
   assign rsp_count_10    = result.words[5];
   assign rsp_count_25    = result.words[6];
   assign rsp_count_50    = result.words[7];
   assign rsp_count_100   = result.words[8];
   assign rsp_checksum_ok = result.checksum_ok;

endmodule
